// File: rtl/core/pgs_pkg.sv
`default_nettype none

package pgs_pkg;

    localparam int PosW   = 32;
    localparam int DtW    = 16;
    localparam int SpeedW = 24;
    localparam int RotW   = 16;
    localparam int SnapW  = 20;
    localparam int CfgW   = 24;
    localparam int CfgIdxW = 2;

    // divider: quotient of (magnitude * amount + len / 2) by len
    localparam int DivNumW = 56;
    localparam int DivDenW = 33;
    localparam int DivCntW = $clog2(DivNumW);

    // square root of a sum of three 62-bit squares
    localparam int SqrtInW  = 64;
    localparam int SqrtOutW = SqrtInW / 2;
    localparam int SqrtCntW = $clog2(SqrtOutW);

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_JUMP  = 2'd1;
    localparam logic [1:0] REQ_GLIDE = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_MOVE_SPEED    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ROTATION_STEP = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SNAP_DISTANCE = 2'd2;

    localparam logic [SpeedW-1:0] MOVE_SPEED_RST    = 24'd851968;
    localparam logic [RotW-1:0]   ROTATION_STEP_RST = 16'd3277;
    localparam logic [SnapW-1:0]  SNAP_DISTANCE_RST = 20'd13107;

    // pi / 180 in unsigned Q0.32
    localparam logic [32:0] DEG2RAD_Q32 = 33'd74961321;
    localparam logic signed [33:0] PI_Q16     = 34'sd205887;
    localparam logic signed [33:0] TWO_PI_Q16 = 34'sd411775;

    // floor(2^50 / two pi), quotient estimate for the angle wrap
    localparam int WrapShift = 50;
    localparam logic [32:0] WRAP_RECIP = 33'd2734259988;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [DtW-1:0]     delta_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] deg_x;
        logic signed [31:0] deg_y;
        logic signed [31:0] deg_z;
    } t_req;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] cur_z;
        logic signed [31:0] ang_x;
        logic signed [31:0] ang_y;
        logic signed [31:0] ang_z;
        logic               gliding;
        logic               turning;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/core/pgs_div.sv
`default_nettype none

module pgs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pgs_pkg::DivNumW-1:0]   i_num,
    input  wire logic [pgs_pkg::DivDenW-1:0]   i_den,
    output logic                               o_done,
    output logic [pgs_pkg::DivNumW-1:0]        o_quo
);
    import pgs_pkg::*;

    logic [DivNumW-1:0] r_quo;
    logic [DivDenW:0]   r_rem;
    logic [DivDenW-1:0] r_den;
    logic [DivCntW-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DivDenW:0]   trial;
    logic               fits;

    assign trial = {r_rem[DivDenW-1:0], r_quo[DivNumW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? trial - {1'b0, r_den} : trial;
                r_quo <= {r_quo[DivNumW-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DivCntW'(DivNumW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: rtl/core/pgs_sqrt.sv
`default_nettype none

module pgs_sqrt (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pgs_pkg::SqrtInW-1:0]    i_val,
    output logic                                o_done,
    output logic [pgs_pkg::SqrtOutW-1:0]        o_root
);
    import pgs_pkg::*;

    logic [SqrtInW-1:0]  r_v;
    logic [SqrtInW-1:0]  r_r;
    logic [SqrtInW-1:0]  r_bit;
    logic [SqrtCntW-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [SqrtInW-1:0]  trial;

    assign trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_val;
                r_r    <= '0;
                r_bit  <= SqrtInW'(1) << (SqrtInW - 2);
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SqrtCntW'(SqrtOutW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SqrtOutW-1:0];

endmodule

`default_nettype wire

// File: rtl/core/pose_glide_stepper_core.sv
`default_nettype none

// Pose glide stepper: holds a Q16.16 position, three Euler angles in radians, a
// destination pose and the gliding / turning flags. A jump request sets the pose,
// a glide request sets the destination and raises both flags, a tick request moves
// the position at move_speed toward the destination (snapping inside snap_distance)
// and turns the angles by rotation_step along the wrapped angle difference. Every
// request gives one response with the pose after it. One shared 33x33 multiplier,
// a restoring divider and a square root unit do all the work under one sequencer,
// one request at a time. A full glide-and-turn tick runs three length evaluations,
// up to three angle wraps (by reciprocal multiplication) and six step divisions.
// A new request is taken while the previous response still waits in the output
// register.
module pose_glide_stepper_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire pgs_pkg::t_req                 i_req,
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_ready,
    output pgs_pkg::t_rsp                      o_rsp,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pgs_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  wire logic [pgs_pkg::CfgW-1:0]      i_cfg_data
);
    import pgs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CONV, S_CONV_W, S_AMT, S_AMT_W, S_DIFF, S_WRAP, S_WRAP_Q, S_WRAP_W,
        S_MAG, S_SQ, S_SQ_W, S_SQRT, S_SQRT_W, S_EVAL, S_SMUL, S_SDIV,
        S_SDIV_W, S_TEND, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_GSTEP, PH_GCHK, PH_TCHK, PH_TSTEP
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    t_req   r_req;
    t_rsp   r_out;
    logic   r_out_valid;

    logic [SpeedW-1:0] r_move_speed;
    logic [RotW-1:0]   r_rotation_step;
    logic [SnapW-1:0]  r_snap_distance;

    logic signed [31:0] r_here_pos [3];
    logic signed [31:0] r_here_ang [3];
    logic signed [31:0] r_goal_pos [3];
    logic signed [31:0] r_goal_ang [3];
    logic               r_glide_on;
    logic               r_turn_on;

    logic signed [33:0] r_d   [3];
    logic [30:0]        r_mag [3];
    logic               r_sh;
    logic [63:0]        r_sum;
    logic [31:0]        r_len;
    logic [SpeedW-1:0]  r_amount;
    logic [1:0]         r_ax;
    logic signed [63:0] r_prod;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic               is_ang;
    logic signed [33:0] d_cur;
    logic               wrap_hi;
    logic               wrap_lo;
    logic signed [33:0] wrap_num;
    logic signed [33:0] wrap_rem0;
    logic signed [33:0] wrap_rem;
    logic [DivNumW-1:0] div_num;
    logic [DivDenW-1:0] div_den;
    logic               div_start;
    logic               div_done;
    logic [DivNumW-1:0] div_quo;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic [32:0]        full_len;
    logic [SpeedW-1:0]  step_amt;
    logic signed [31:0] deg_sel;
    logic signed [31:0] pos_sel;
    logic signed [63:0] rad_sum;
    logic signed [31:0] rad;
    logic signed [33:0] wrap_res;
    logic [32:0]        abs_d [3];
    logic               need_sh;
    logic signed [31:0] step_base;
    logic signed [31:0] step_res;
    logic [39:0]        amt_sum;
    logic               ang_eq;

    function automatic logic signed [31:0] sat_step(input logic signed [31:0] v,
                                                    input logic neg,
                                                    input logic [DivNumW-1:0] c);
        logic signed [57:0] ve;
        logic signed [57:0] ce;
        logic signed [57:0] s;
        ve = 58'(v);
        ce = signed'({2'b00, c});
        s  = neg ? ve - ce : ve + ce;
        if (s > 58'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -58'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    assign is_ang = (r_phase == PH_TCHK) || (r_phase == PH_TSTEP);
    assign d_cur  = r_d[r_ax];
    assign wrap_hi = d_cur > PI_Q16;
    assign wrap_lo = d_cur < -PI_Q16;

    always_comb begin
        case (r_ax)
            2'd0: begin
                deg_sel = r_req.deg_x;
                pos_sel = r_req.pos_x;
            end
            2'd1: begin
                deg_sel = r_req.deg_y;
                pos_sel = r_req.pos_y;
            end
            default: begin
                deg_sel = r_req.deg_z;
                pos_sel = r_req.pos_z;
            end
        endcase
    end

    assign step_amt = (r_phase == PH_TSTEP) ? SpeedW'(r_rotation_step) : r_amount;

    // excess beyond pi, always below 2^32
    assign wrap_num = wrap_hi ? d_cur - PI_Q16 : -PI_Q16 - d_cur;

    // shared multiplier operand selection
    always_comb begin
        case (r_state)
            S_CONV: begin
                mul_a = 33'(deg_sel);
                mul_b = signed'(DEG2RAD_Q32);
            end
            S_AMT: begin
                mul_a = signed'(33'(r_req.delta_time));
                mul_b = signed'(33'(r_move_speed));
            end
            S_WRAP: begin
                mul_a = 33'(wrap_num);
                mul_b = signed'(WRAP_RECIP);
            end
            S_WRAP_Q: begin
                mul_a = signed'(33'(r_prod[63:WrapShift]));
                mul_b = 33'(TWO_PI_Q16);
            end
            S_SQ: begin
                mul_a = signed'(33'(r_mag[r_ax]));
                mul_b = signed'(33'(r_mag[r_ax]));
            end
            default: begin
                mul_a = signed'(33'(r_mag[r_ax]));
                mul_b = signed'(33'(step_amt));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign rad_sum = r_prod + 64'sd2147483648;
    assign rad     = rad_sum[63:32];
    assign amt_sum = r_prod[39:0] + 40'd32768;

    assign div_num = r_prod[DivNumW-1:0] + DivNumW'(r_len >> 1);
    assign div_den = DivDenW'(r_len);

    assign div_start  = (r_state == S_SDIV);
    assign sqrt_start = (r_state == S_SQRT);

    // quotient estimate is exact or one low
    assign wrap_rem0 = wrap_num - signed'(r_prod[33:0]);
    assign wrap_rem  = (wrap_rem0 >= TWO_PI_Q16) ? wrap_rem0 - TWO_PI_Q16 : wrap_rem0;

    always_comb begin
        if (wrap_hi) begin
            wrap_res = (wrap_rem == '0) ? PI_Q16 : wrap_rem + PI_Q16 - TWO_PI_Q16;
        end else begin
            wrap_res = (wrap_rem == '0) ? -PI_Q16 : TWO_PI_Q16 - PI_Q16 - wrap_rem;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_d[i] = r_d[i][33] ? 33'(-r_d[i]) : 33'(r_d[i]);
        end
        need_sh = abs_d[0][31] || abs_d[1][31] || abs_d[2][31];
    end

    assign full_len  = r_sh ? {r_len, 1'b0} : {1'b0, r_len};
    assign step_base = is_ang ? r_here_ang[r_ax] : r_here_pos[r_ax];
    assign step_res  = sat_step(step_base, d_cur[33], div_quo);
    assign ang_eq    = (r_here_ang[0] == r_goal_ang[0]) && (r_here_ang[1] == r_goal_ang[1])
                    && (r_here_ang[2] == r_goal_ang[2]);

    pgs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    pgs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (r_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_phase         <= PH_GSTEP;
            r_out_valid     <= 1'b0;
            r_move_speed    <= MOVE_SPEED_RST;
            r_rotation_step <= ROTATION_STEP_RST;
            r_snap_distance <= SNAP_DISTANCE_RST;
            r_glide_on      <= 1'b0;
            r_turn_on       <= 1'b0;
            r_ax            <= '0;
            for (int i = 0; i < 3; i++) begin
                r_here_pos[i] <= '0;
                r_here_ang[i] <= '0;
                r_goal_pos[i] <= '0;
                r_goal_ang[i] <= '0;
            end
        end else begin
            r_prod <= mul_p[63:0];

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MOVE_SPEED:    r_move_speed    <= i_cfg_data;
                    CFG_ROTATION_STEP: r_rotation_step <= i_cfg_data[RotW-1:0];
                    CFG_SNAP_DISTANCE: r_snap_distance <= i_cfg_data[SnapW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_rsp_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        r_ax  <= '0;
                        case (i_req.req_type)
                            REQ_TICK: begin
                                if (r_glide_on) begin
                                    r_state <= S_AMT;
                                end else if (r_turn_on) begin
                                    r_phase <= PH_TCHK;
                                    r_state <= S_DIFF;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            REQ_JUMP, REQ_GLIDE: r_state <= S_CONV;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_CONV: r_state <= S_CONV_W;
                S_CONV_W: begin
                    if (r_req.req_type == REQ_JUMP) begin
                        r_here_pos[r_ax] <= pos_sel;
                        r_here_ang[r_ax] <= rad;
                    end else begin
                        r_goal_pos[r_ax] <= pos_sel;
                        r_goal_ang[r_ax] <= rad;
                    end
                    if (r_ax == 2'd2) begin
                        if (r_req.req_type == REQ_GLIDE) begin
                            r_glide_on <= 1'b1;
                            r_turn_on  <= 1'b1;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_CONV;
                    end
                end
                S_AMT: r_state <= S_AMT_W;
                S_AMT_W: begin
                    r_amount <= amt_sum[39:16];
                    r_phase  <= PH_GSTEP;
                    r_state  <= S_DIFF;
                end
                S_DIFF: begin
                    for (int i = 0; i < 3; i++) begin
                        r_d[i] <= is_ang ? 34'(r_goal_ang[i]) - 34'(r_here_ang[i])
                                         : 34'(r_goal_pos[i]) - 34'(r_here_pos[i]);
                    end
                    r_ax    <= '0;
                    r_state <= is_ang ? S_WRAP : S_MAG;
                end
                S_WRAP: begin
                    if (wrap_hi || wrap_lo) begin
                        r_state <= S_WRAP_Q;
                    end else if (r_ax == 2'd2) begin
                        r_state <= S_MAG;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                    end
                end
                S_WRAP_Q: r_state <= S_WRAP_W;
                S_WRAP_W: begin
                    r_d[r_ax] <= wrap_res;
                    if (r_ax == 2'd2) begin
                        r_state <= S_MAG;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_WRAP;
                    end
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= need_sh ? abs_d[i][31:1] : abs_d[i][30:0];
                    end
                    r_sh    <= need_sh;
                    r_sum   <= '0;
                    r_ax    <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_SQ_W;
                S_SQ_W: begin
                    r_sum <= r_sum + r_prod;
                    if (r_ax == 2'd2) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_ax    <= r_ax + 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_SQRT: r_state <= S_SQRT_W;
                S_SQRT_W: begin
                    if (sqrt_done) begin
                        r_len   <= sqrt_root;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_ax <= '0;
                    case (r_phase)
                        PH_GSTEP: begin
                            if (r_len == '0) begin
                                r_phase <= PH_GCHK;
                                r_state <= S_DIFF;
                            end else begin
                                r_state <= S_SMUL;
                            end
                        end
                        PH_GCHK: begin
                            if (full_len < 33'(r_snap_distance)) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_here_pos[i] <= r_goal_pos[i];
                                end
                                r_glide_on <= 1'b0;
                            end
                            if (r_turn_on) begin
                                r_phase <= PH_TCHK;
                                r_state <= S_DIFF;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        default: begin
                            if (full_len < 33'(r_rotation_step)) begin
                                for (int i = 0; i < 3; i++) begin
                                    r_here_ang[i] <= r_goal_ang[i];
                                end
                                r_state <= S_TEND;
                            end else begin
                                r_phase <= PH_TSTEP;
                                r_state <= (r_len == '0) ? S_TEND : S_SMUL;
                            end
                        end
                    endcase
                end
                S_SMUL: r_state <= S_SDIV;
                S_SDIV: r_state <= S_SDIV_W;
                S_SDIV_W: begin
                    if (div_done) begin
                        if (is_ang) begin
                            r_here_ang[r_ax] <= step_res;
                        end else begin
                            r_here_pos[r_ax] <= step_res;
                        end
                        if (r_ax == 2'd2) begin
                            if (is_ang) begin
                                r_state <= S_TEND;
                            end else begin
                                r_phase <= PH_GCHK;
                                r_state <= S_DIFF;
                            end
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_SMUL;
                        end
                    end
                end
                S_TEND: begin
                    if (ang_eq) begin
                        r_turn_on <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_rsp_ready) begin
                        r_out.cur_x   <= r_here_pos[0];
                        r_out.cur_y   <= r_here_pos[1];
                        r_out.cur_z   <= r_here_pos[2];
                        r_out.ang_x   <= r_here_ang[0];
                        r_out.ang_y   <= r_here_ang[1];
                        r_out.ang_z   <= r_here_ang[2];
                        r_out.gliding <= r_glide_on;
                        r_out.turning <= r_turn_on;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
